>>> src/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 decoder: status codes, decoder state and result record.
// No dependencies; u8u16_decode and utf8_to_utf16_decoder_unit import it.
`timescale 1ns / 1ps
`default_nettype none
package u8u16_pkg;

  typedef enum logic [2:0] {
    ST_UNIT       = 3'd0,
    ST_BAD_LEAD   = 3'd1,
    ST_BAD_CONT   = 3'd2,
    ST_BAD_SCALAR = 3'd3,
    ST_TRUNCATED  = 3'd4,
    ST_CLEAN_END  = 3'd5
  } status_e;

  localparam logic       OP_DATA = 1'b0;
  localparam logic       OP_EOS  = 1'b1;

  localparam logic [7:0]  LEAD2_MIN     = 8'hC2;
  localparam logic [7:0]  LEAD2_MAX     = 8'hDF;
  localparam logic [7:0]  LEAD3_MIN     = 8'hE0;
  localparam logic [7:0]  LEAD3_MAX     = 8'hEF;
  localparam logic [7:0]  LEAD4_MIN     = 8'hF0;
  localparam logic [7:0]  LEAD4_MAX     = 8'hF4;
  localparam logic [20:0] MIN_LEN2      = 21'h00080;
  localparam logic [20:0] MIN_LEN3      = 21'h00800;
  localparam logic [20:0] MIN_LEN4      = 21'h10000;
  localparam logic [20:0] SCALAR_MAX    = 21'h10FFFF;
  localparam logic [20:0] BMP_MAX       = 21'h00FFFF;
  localparam logic [20:0] SURR_LOW      = 21'h00D800;
  localparam logic [20:0] SURR_HIGH     = 21'h00DFFF;
  localparam logic [20:0] SUPPL_BASE    = 21'h010000;
  localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;

  typedef struct packed {
    logic [20:0] partial;
    logic [1:0]  pending;
    logic [1:0]  seq_len;
  } dec_state_t;

  typedef struct packed {
    logic        emit;
    logic        pair;
    logic [15:0] unit0;
    logic [15:0] unit1;
    status_e     status;
  } dec_rec_t;

endpackage
`default_nettype wire

>>> src/u8u16_if.sv
// Handshake interfaces for the byte input and the code-unit output of the decoder.
// Depends on nothing but the valid/ready convention; no package needed.
`timescale 1ns / 1ps
`default_nettype none
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [2:0]  status;
  logic        last_of_run;

  modport source (output valid, output code_unit, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_unit, input status, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

>>> src/u8u16_decode.sv
// Combinational step of the decoder: takes the sequence state and one word, gives the
// next state and a result record. Depends on u8u16_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u8u16_decode import u8u16_pkg::*; (
  input  dec_state_t st_i,
  input  logic       op_i,
  input  logic [7:0] byte_i,
  output dec_state_t st_o,
  output dec_rec_t   rec_o
);

  logic [20:0] acc;
  logic [1:0]  pend_m1;
  logic [20:0] minimum;
  logic [20:0] offset;

  assign acc     = {st_i.partial[14:0], byte_i[5:0]};
  assign pend_m1 = st_i.pending - 2'd1;
  assign offset  = acc - SUPPL_BASE;

  always_comb begin
    case (st_i.seq_len)
      2'd1:    minimum = MIN_LEN2;
      2'd2:    minimum = MIN_LEN3;
      default: minimum = MIN_LEN4;
    endcase
  end

  always_comb begin
    st_o         = st_i;
    rec_o        = '0;
    rec_o.status = ST_UNIT;
    if (op_i == OP_EOS) begin
      st_o         = '0;
      rec_o.emit   = 1'b1;
      if (st_i.pending != 2'd0) begin
        rec_o.status = ST_TRUNCATED;
      end else begin
        rec_o.status = ST_CLEAN_END;
      end
    end else if (st_i.pending == 2'd0) begin
      if (!byte_i[7]) begin
        rec_o.emit  = 1'b1;
        rec_o.unit0 = {8'h00, byte_i};
      end else if (byte_i >= LEAD2_MIN && byte_i <= LEAD2_MAX) begin
        st_o.partial = {16'h0000, byte_i[4:0]};
        st_o.seq_len = 2'd1;
        st_o.pending = 2'd1;
      end else if (byte_i >= LEAD3_MIN && byte_i <= LEAD3_MAX) begin
        st_o.partial = {17'h00000, byte_i[3:0]};
        st_o.seq_len = 2'd2;
        st_o.pending = 2'd2;
      end else if (byte_i >= LEAD4_MIN && byte_i <= LEAD4_MAX) begin
        st_o.partial = {18'h00000, byte_i[2:0]};
        st_o.seq_len = 2'd3;
        st_o.pending = 2'd3;
      end else begin
        st_o         = '0;
        rec_o.emit   = 1'b1;
        rec_o.status = ST_BAD_LEAD;
      end
    end else if (byte_i[7:6] != 2'b10) begin
      st_o         = '0;
      rec_o.emit   = 1'b1;
      rec_o.status = ST_BAD_CONT;
    end else if (pend_m1 != 2'd0) begin
      st_o.partial = acc;
      st_o.pending = pend_m1;
    end else begin
      st_o       = '0;
      rec_o.emit = 1'b1;
      if (acc < minimum || acc > SCALAR_MAX || (acc >= SURR_LOW && acc <= SURR_HIGH)) begin
        rec_o.status = ST_BAD_SCALAR;
      end else if (acc <= BMP_MAX) begin
        rec_o.unit0 = acc[15:0];
      end else begin
        rec_o.pair  = 1'b1;
        rec_o.unit0 = HI_SURR_BASE | {6'b000000, offset[19:10]};
        rec_o.unit1 = LO_SURR_BASE | {6'b000000, offset[9:0]};
      end
    end
  end

endmodule
`default_nettype wire

>>> src/utf8_to_utf16_decoder_unit.sv
// Strict UTF-8 to UTF-16 decoder: one byte word in, code-unit or status words out.
// Depends on u8u16_pkg, u8u16_if and u8u16_decode.
// An accepted byte word is held in the input register; its result word is queued.
// The low surrogate of a pair is offered in the cycle after the high one is taken.
// Throughput: one byte word per cycle; the input stalls only while the two-entry
// result queue is full and its head is not taken. Reset empties the input register,
// the sequence state and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_utf16_decoder_unit import u8u16_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  u8u16_in_if.sink     in_i,
  u8u16_out_if.source  out_o
);

  logic       s1_valid_q;
  logic       s1_op_q;
  logic [7:0] s1_byte_q;
  dec_state_t st_q, st_d;
  dec_rec_t   rec;
  dec_rec_t   fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q, half_q;
  logic [1:0] count_q;
  dec_rec_t   head;
  logic       advance, push, pop, out_fire;

  u8u16_decode u_decode (
    .st_i   (st_q),
    .op_i   (s1_op_q),
    .byte_i (s1_byte_q),
    .st_o   (st_d),
    .rec_o  (rec)
  );

  assign head     = fifo_q[rd_ptr_q];
  assign out_fire = out_o.valid && out_o.ready;
  assign pop      = out_fire && (!head.pair || half_q);
  assign advance  = s1_valid_q && ((count_q != 2'd2) || pop);
  assign push     = advance && rec.emit;
  assign in_i.ready = !s1_valid_q || advance;

  assign out_o.valid       = (count_q != 2'd0);
  assign out_o.code_unit   = (head.pair && half_q) ? head.unit1 : head.unit0;
  assign out_o.status      = head.status;
  assign out_o.last_of_run = !head.pair || half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      st_q       <= '0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      half_q     <= 1'b0;
      count_q    <= 2'd0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        st_q <= st_d;
      end
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
        half_q   <= 1'b0;
      end else if (out_fire) begin
        half_q <= 1'b1;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q   <= in_i.op;
      s1_byte_q <= in_i.data_byte;
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= rec;
    end
  end

endmodule
`default_nettype wire

>>> bench/utf8_to_utf16_decoder_unit_tb.sv
// Self-checking bench for utf8_to_utf16_decoder_unit: directed and random byte streams.
// A scoreboard class decodes every accepted byte word and checks each code-unit word.
// Depends on u8u16_pkg, u8u16_if and utf8_to_utf16_decoder_unit from src.
`timescale 1ns / 1ps
module utf8_to_utf16_decoder_unit_tb;
  import u8u16_pkg::*;

  typedef struct {
    logic [15:0] unit;
    status_e     status;
    logic        last;
  } unit_exp_t;

  class utf16_scoreboard;
    unit_exp_t   expected_units[$];
    logic [20:0] partial;
    logic [1:0]  pending;
    logic [1:0]  seq_len;
    int unsigned mismatches;

    function new();
      go_idle();
      mismatches = 0;
    endfunction

    function void go_idle();
      partial = '0;
      pending = '0;
      seq_len = '0;
    endfunction

    function void add_unit(logic [15:0] unit, status_e status, logic last);
      unit_exp_t e;
      e.unit = unit;
      e.status = status;
      e.last = last;
      expected_units.insert(expected_units.size(), e);
    endfunction

    function int outstanding();
      return expected_units.size();
    endfunction

    function void note_byte(logic op, logic [7:0] b);
      logic [20:0] cp;
      logic [20:0] minimum;
      logic [20:0] off;
      if (op == OP_EOS) begin
        add_unit('0, status_e'((pending != 0) ? ST_TRUNCATED : ST_CLEAN_END), 1'b1);
        go_idle();
      end else if (pending == 0) begin
        if (!b[7]) begin
          add_unit({8'h00, b}, ST_UNIT, 1'b1);
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          partial = {16'h0, b[4:0]};
          seq_len = 2'd1;
          pending = 2'd1;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          partial = {17'h0, b[3:0]};
          seq_len = 2'd2;
          pending = 2'd2;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          partial = {18'h0, b[2:0]};
          seq_len = 2'd3;
          pending = 2'd3;
        end else begin
          go_idle();
          add_unit('0, ST_BAD_LEAD, 1'b1);
        end
      end else if (b[7:6] != 2'b10) begin
        go_idle();
        add_unit('0, ST_BAD_CONT, 1'b1);
      end else begin
        partial = {partial[14:0], b[5:0]};
        pending = pending - 2'd1;
        if (pending == 0) begin
          cp = partial;
          minimum = (seq_len == 2'd1) ? MIN_LEN2 : (seq_len == 2'd2) ? MIN_LEN3 : MIN_LEN4;
          go_idle();
          if (cp < minimum || cp > SCALAR_MAX || (cp >= SURR_LOW && cp <= SURR_HIGH)) begin
            add_unit('0, ST_BAD_SCALAR, 1'b1);
          end else if (cp <= BMP_MAX) begin
            add_unit(cp[15:0], ST_UNIT, 1'b1);
          end else begin
            off = cp - SUPPL_BASE;
            add_unit(HI_SURR_BASE + {6'h0, off[19:10]}, ST_UNIT, 1'b0);
            add_unit(LO_SURR_BASE + {6'h0, off[9:0]}, ST_UNIT, 1'b1);
          end
        end
      end
    endfunction

    task report(string what);
      $display("ERROR at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    task check_unit(logic [15:0] unit, logic [2:0] status, logic last);
      unit_exp_t e;
      if (expected_units.size() == 0) begin
        report($sformatf("unexpected word unit %h status %0d last %b", unit, status, last));
      end else begin
        e = expected_units.pop_front();
        if (unit !== e.unit || status !== e.status || last !== e.last)
          report($sformatf("got unit %h status %0d last %b, wanted unit %h %s last %b",
                           unit, status, last, e.unit, e.status.name(), e.last));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  bit   hold_req;
  int unsigned sent;
  logic [8:0] burst[$];
  utf16_scoreboard sb;

  u8u16_in_if  in_if ();
  u8u16_out_if out_if ();

  utf8_to_utf16_decoder_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void append_word(logic [8:0] w);
    burst.insert(burst.size(), w);
  endfunction

  function automatic void add_utf8(logic [20:0] cp, int unsigned len);
    case (len)
      1: append_word({OP_DATA, 1'b0, cp[6:0]});
      2: begin
        append_word({OP_DATA, 3'b110, cp[10:6]});
        append_word({OP_DATA, 2'b10, cp[5:0]});
      end
      3: begin
        append_word({OP_DATA, 4'b1110, cp[15:12]});
        append_word({OP_DATA, 2'b10, cp[11:6]});
        append_word({OP_DATA, 2'b10, cp[5:0]});
      end
      default: begin
        append_word({OP_DATA, 5'b11110, cp[20:18]});
        append_word({OP_DATA, 2'b10, cp[17:12]});
        append_word({OP_DATA, 2'b10, cp[11:6]});
        append_word({OP_DATA, 2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] valid_scalar(int unsigned len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= SURR_LOW && cp <= SURR_HIGH) cp = cp ^ 21'h8000;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  function automatic void build_random_run();
    int unsigned kind;
    int unsigned len;
    int unsigned keep;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    burst.delete();
    if (kind < 55) begin
      len = $urandom_range(1, 4);
      add_utf8(valid_scalar(len), len);
    end else if (kind < 65) begin
      case ($urandom_range(0, 2))
        0: add_utf8(21'($urandom_range('hD800, 'hDFFF)), 3);
        1: begin
          len = $urandom_range(2, 4);
          add_utf8(21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF)),
                   len);
        end
        default: add_utf8(21'($urandom_range('h110000, 'h13FFFF)), 4);
      endcase
    end else if (kind < 80) begin
      len = $urandom_range(2, 4);
      add_utf8(valid_scalar(len), len);
      keep = $urandom_range(1, len - 1);
      while (burst.size() > keep) void'(burst.pop_back());
      if ($urandom_range(0, 1)) begin
        append_word({OP_EOS, 8'($urandom())});
      end else begin
        b = 8'($urandom());
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        append_word({OP_DATA, b});
      end
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 4)) append_word({OP_DATA, 8'($urandom())});
    end else begin
      append_word({OP_EOS, 8'($urandom())});
    end
  endfunction

  task automatic send_byte(logic [8:0] w);
    in_if.valid <= 1'b1;
    in_if.op <= w[8];
    in_if.data_byte <= w[7:0];
    do @(posedge clk); while (!in_if.ready);
    sb.note_byte(w[8], w[7:0]);
    sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready)
        sb.check_unit(out_if.code_unit, out_if.status, out_if.last_of_run);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 299;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [8:0] directed_words[$];
    bit         held;
    bit         drained;
    int unsigned guard;
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    held = 1'b0;
    drained = 1'b0;
    sent = 0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.op <= OP_DATA;
    in_if.data_byte <= 8'h00;
    directed_words = '{
      {OP_DATA, 8'h00}, {OP_DATA, 8'hFF}, {OP_DATA, 8'h7F},
      {OP_DATA, 8'hC2}, {OP_DATA, 8'h80},
      {OP_DATA, 8'hEF}, {OP_DATA, 8'hBF}, {OP_DATA, 8'hBF},
      {OP_DATA, 8'hED}, {OP_DATA, 8'hA0}, {OP_DATA, 8'h80},
      {OP_DATA, 8'hE0}, {OP_DATA, 8'h9F}, {OP_DATA, 8'hBF},
      {OP_DATA, 8'hF4}, {OP_DATA, 8'h8F}, {OP_DATA, 8'hBF}, {OP_DATA, 8'hBF},
      {OP_DATA, 8'hF4}, {OP_DATA, 8'h90}, {OP_DATA, 8'h80}, {OP_DATA, 8'h80},
      {OP_DATA, 8'hC2}, {OP_DATA, 8'h41},
      {OP_DATA, 8'hF0}, {OP_DATA, 8'h90}, {OP_EOS, 8'hA5},
      {OP_EOS, 8'h5A}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_words[i]) send_byte(directed_words[i]);

    while (sent < 1700) begin
      if (!held && sent >= 400) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!drained && sent >= 900) begin
        drained = 1'b1;
        in_if.valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
      end
      if (sent >= 1450) calm = 1'b1;
      build_random_run();
      foreach (burst[i]) send_byte(burst[i]);
    end
    in_if.valid <= 1'b0;

    for (guard = 0; guard < 5000 && sb.outstanding() != 0; guard++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d expected words never arrived", sb.outstanding()));
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
